>>> sv/wil_pkg.sv
// wil_pkg: shared types, constants and sample conversion for the wav impulse loader
`timescale 1ns / 1ps
`default_nettype none
package wil_pkg;

  localparam int OFF_W  = 34;   // file offsets incl. a 32-bit chunk length
  localparam int DIV_W  = 32;   // data chunk length
  localparam int DVS_W  = 4;    // bytes per frame
  localparam int CNT_W  = 5;

  localparam logic [63:0] FNV_BASIS   = 64'd1469598103934665603;
  localparam logic [63:0] FNV_PRIME_L = 64'd435;   // prime = 2^40 + 435

  // tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] REG_EXPECTED_HASH = 2'd0;
  localparam logic [1:0] REG_HASH_ENABLE   = 2'd1;
  localparam logic [1:0] REG_ENGINE_RATE   = 2'd2;
  localparam logic [1:0] REG_LEAD_POINT    = 2'd3;

  localparam logic [1:0] KIND_PCM16 = 2'd0;
  localparam logic [1:0] KIND_PCM24 = 2'd1;
  localparam logic [1:0] KIND_F32   = 2'd2;

  localparam logic [15:0] WAVE_FMT_PCM   = 16'd1;
  localparam logic [15:0] WAVE_FMT_FLOAT = 16'd3;

  typedef enum logic [3:0] {
    ST_OK, ST_NOT_WAV, ST_MISSING, ST_CHANNELS, ST_FORMAT,
    ST_EMPTY, ST_HASH, ST_RATE, ST_TOO_LARGE, ST_NO_DATA
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FETCH, S_RIFF, S_WAVE, S_WALK, S_CHUNK,
    S_FMTCHK, S_FMT1, S_FMT2, S_DIV, S_FRAMES, S_FRAME
  } state_t;

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x * FNV_PRIME_L);
  endfunction

  function automatic logic signed [23:0] f32_to_q23(input logic [31:0] b);
    logic [7:0]  ex;
    logic [7:0]  shamt;
    logic [23:0] m;
    logic [23:0] mag;
    logic [23:0] res;
    ex    = b[30:23];
    m     = {1'b1, b[22:0]};
    shamt = 8'd127 - ex;
    mag   = (shamt >= 8'd24) ? 24'd0 : (m >> shamt[4:0]);
    if (ex == 8'hFF) begin
      res = (b[22:0] != 23'd0) ? 24'd0 : (b[31] ? 24'h800000 : 24'h7FFFFF);
    end else if (ex == 8'd0) begin
      res = 24'd0;
    end else if (ex >= 8'd127) begin
      res = b[31] ? 24'h800000 : 24'h7FFFFF;
    end else begin
      res = b[31] ? (24'd0 - mag) : mag;
    end
    return res;
  endfunction

  function automatic logic signed [23:0] sample_decode(input logic [1:0] k,
                                                       input logic [31:0] w);
    logic [23:0] res;
    case (k)
      KIND_PCM16: res = {w[15:0], 8'h00};
      KIND_PCM24: res = w[23:0];
      default:    res = f32_to_q23(w);
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/wil_ram.sv
// wil_ram: generic single-write, single-read memory with registered read
`timescale 1ns / 1ps
`default_nettype none
module wil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/wil_div.sv
// wil_div: bit-serial restoring divider for frame count
`timescale 1ns / 1ps
`default_nettype none
module wil_div import wil_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem[DVS_W-1:0], quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? (trial - {1'b0, dvs}) : trial;
        quotient <= {quotient[DIV_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/wav_impulse_loader.sv
// wav_impulse_loader: wav file loader, fnv-1a style hash check, riff walk and frame fetch
//
// A byte request (opcode 0) stores its byte in the byte memory while there is
// room and updates the 64-bit FNV-1a style hash. The request that carries the end
// mark then runs the load: checks, then a walk over the RIFF chunks reading
// the memory one byte a cycle, then a serial divide for the frame count, after
// which one status report comes out.
// A frame request (opcode 1) reads the frame's 2 to 8 bytes from the memory,
// one a cycle, then gives the frame, or a no-data status if no frame is left.
// One request is worked on at a time; no reset clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module wav_impulse_loader import wil_pkg::*; #(
  parameter int MAX_BYTES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [7:0]         file_byte,
  input  wire logic               end_of_file,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    kind,
  output logic [3:0]              status,
  output logic signed [23:0]      left_sample,
  output logic signed [23:0]      right_sample,
  output logic [1:0]              channel_count,
  output logic [31:0]             file_rate,
  output logic [15:0]             frame_count,
  output logic                    last_frame
);
  localparam int AW = $clog2(MAX_BYTES);
  localparam int CW = $clog2(MAX_BYTES + 1);

  // configuration
  logic [63:0] expected_hash;
  logic        hash_check_enable;
  logic [18:0] engine_rate;
  logic        lead_point;

  // load state
  logic [CW-1:0] byte_count;
  logic [63:0]   running_hash;
  logic          overflowed;
  logic          file_closed;
  logic          loaded_ok;
  logic [CW-1:0] data_start;
  logic [15:0]   frames_total;
  logic [1:0]    sample_kind;
  logic          stereo_flag;
  logic [15:0]   read_index;

  // chunk walk
  logic [OFF_W-1:0] off;
  logic [CW-1:0]    fmt_at;
  logic [CW-1:0]    dat_at;
  logic [31:0]      dat_len;
  logic             has_fmt;
  logic             has_dat;
  logic [15:0]      fmt_code;
  logic [15:0]      chan_r;
  logic [31:0]      fmt_rate;

  // byte fetch engine
  logic [OFF_W-1:0] f_base;
  logic [3:0]       f_len;
  logic [3:0]       f_issue;
  logic             f_pend;
  logic [2:0]       f_pidx;
  logic             f_inr;
  logic [63:0]      acc;
  state_t           ret_state;

  state_t state, state_next;

  // comb outputs of the sequencer
  logic             fetch_go;
  logic [OFF_W-1:0] fetch_base;
  logic [3:0]       fetch_len;
  state_t           fetch_ret;
  logic             rep_go;
  status_t          rep_status;
  logic             rep_rate;
  logic             frm_go;
  logic             div_start;

  logic             in_acc;
  logic             out_acc;
  logic [CW-1:0]    cnt_base;
  logic [63:0]      hash_base;
  logic             ovf_base;
  logic             push_store;

  logic [OFF_W-1:0] rd_addr;
  logic             rd_inr;
  logic [7:0]       ram_rdata;

  logic             check_fail;
  status_t          check_status;
  logic             walk_fits;
  logic [OFF_W-1:0] chunk_end;
  logic             chunk_over;
  logic [OFF_W-1:0] off_p8;
  logic             chan_bad;
  logic             kind_ok;
  logic [1:0]       kind_w;
  logic [DVS_W-1:0] frame_b_w;
  logic [DIV_W-1:0] quotient;
  logic             div_done;
  logic [31:0]      frames_capped;
  logic [15:0]      frames_sat;
  logic             rate_bad;
  logic             frame_avail;
  logic [3:0]       bps_cur;
  logic [DVS_W-1:0] frame_b_cur;
  logic [19:0]      rd_off;
  logic [31:0]      right_word;
  logic signed [23:0] l_smp;
  logic signed [23:0] r_smp;
  logic signed [24:0] lr_sum;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  assign cnt_base   = file_closed ? '0 : byte_count;
  assign hash_base  = file_closed ? FNV_BASIS : running_hash;
  assign ovf_base   = file_closed ? 1'b0 : overflowed;
  assign push_store = (state == S_IDLE) && in_acc && !opcode && (cnt_base < CW'(MAX_BYTES));

  assign rd_addr = f_base + OFF_W'(f_issue);
  assign rd_inr  = rd_addr < OFF_W'(byte_count);

  wil_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_store (
    .clk   (clk),
    .we    (push_store),
    .waddr (cnt_base[AW-1:0]),
    .wdata (file_byte),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // load checks
  always_comb begin
    check_fail   = 1'b1;
    check_status = ST_NOT_WAV;
    if (overflowed) begin
      check_status = ST_TOO_LARGE;
    end else if (hash_check_enable && running_hash != expected_hash) begin
      check_status = ST_HASH;
    end else if (byte_count < CW'(44)) begin
      check_status = ST_NOT_WAV;
    end else begin
      check_fail = 1'b0;
    end
  end

  assign off_p8     = off + OFF_W'(8);
  assign walk_fits  = off_p8 <= OFF_W'(byte_count);
  assign chunk_end  = off_p8 + OFF_W'(acc[63:32]);
  assign chunk_over = chunk_end > OFF_W'(byte_count);

  always_comb begin
    chan_bad = !(chan_r inside {16'd1, 16'd2});
    kind_ok  = 1'b1;
    kind_w   = KIND_PCM16;
    if (fmt_code == WAVE_FMT_PCM && acc[15:0] == 16'd16) begin
      kind_w = KIND_PCM16;
    end else if (fmt_code == WAVE_FMT_PCM && acc[15:0] == 16'd24) begin
      kind_w = KIND_PCM24;
    end else if (fmt_code == WAVE_FMT_FLOAT && acc[15:0] == 16'd32) begin
      kind_w = KIND_F32;
    end else begin
      kind_ok = 1'b0;
    end
    // bits/8 for 16, 24, 32 bits
    frame_b_w = (chan_r == 16'd2) ? {acc[5:3], 1'b0} : {1'b0, acc[5:3]};
  end

  wil_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dat_len),
    .divisor  (frame_b_w),
    .done     (div_done),
    .quotient (quotient)
  );

  assign rate_bad      = (engine_rate != 19'd0) && (fmt_rate != 32'(engine_rate));
  assign frames_capped = (engine_rate != 19'd0) && (quotient > 32'({engine_rate, 1'b0}))
                         ? 32'({engine_rate, 1'b0}) : quotient;
  assign frames_sat    = (frames_capped > 32'd65535) ? 16'hFFFF : frames_capped[15:0];

  // frame fetch
  assign frame_avail = loaded_ok && (read_index < frames_total);
  always_comb begin
    case (sample_kind)
      KIND_PCM16: bps_cur = 4'd2;
      KIND_PCM24: bps_cur = 4'd3;
      default:    bps_cur = 4'd4;
    endcase
    frame_b_cur = stereo_flag ? (bps_cur << 1) : bps_cur;
    rd_off      = 20'(read_index) * 20'(frame_b_cur);
    case (sample_kind)
      KIND_PCM16: right_word = acc[47:16];
      KIND_PCM24: right_word = acc[55:24];
      default:    right_word = acc[63:32];
    endcase
    l_smp  = sample_decode(sample_kind, acc[31:0]);
    r_smp  = stereo_flag ? sample_decode(sample_kind, right_word) : 24'sd0;
    lr_sum = {l_smp[23], l_smp} + {r_smp[23], r_smp};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && !opcode && end_of_file) begin
          state_next = S_CHECK;
        end else if (in_acc && opcode && frame_avail) begin
          state_next = S_FETCH;
        end
      end
      S_CHECK:  state_next = check_fail ? S_IDLE : S_FETCH;
      S_FETCH:  if (f_issue == f_len && !f_pend) state_next = ret_state;
      S_RIFF:   state_next = (acc[31:0] != TAG_RIFF) ? S_IDLE : S_FETCH;
      S_WAVE:   state_next = (acc[31:0] != TAG_WAVE) ? S_IDLE : S_WALK;
      S_WALK:   state_next = walk_fits ? S_FETCH : S_FMTCHK;
      S_CHUNK:  state_next = chunk_over ? S_FMTCHK : S_WALK;
      S_FMTCHK: state_next = (has_fmt && has_dat) ? S_FETCH : S_IDLE;
      S_FMT1:   state_next = S_FETCH;
      S_FMT2:   state_next = (chan_bad || !kind_ok) ? S_IDLE : S_DIV;
      S_DIV:    if (div_done) state_next = S_FRAMES;
      S_FRAMES: state_next = S_IDLE;
      S_FRAME:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    fetch_go   = 1'b0;
    fetch_base = '0;
    fetch_len  = 4'd0;
    fetch_ret  = S_IDLE;
    rep_go     = 1'b0;
    rep_status = ST_OK;
    rep_rate   = 1'b0;
    frm_go     = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc && opcode) begin
          if (frame_avail) begin
            fetch_go   = 1'b1;
            fetch_base = OFF_W'(data_start) + OFF_W'(rd_off);
            fetch_len  = frame_b_cur;
            fetch_ret  = S_FRAME;
          end else begin
            rep_go     = 1'b1;
            rep_status = ST_NO_DATA;
          end
        end
      end
      S_CHECK: begin
        if (check_fail) begin
          rep_go     = 1'b1;
          rep_status = check_status;
        end else begin
          fetch_go  = 1'b1;
          fetch_len = 4'd4;
          fetch_ret = S_RIFF;
        end
      end
      S_RIFF: begin
        if (acc[31:0] != TAG_RIFF) begin
          rep_go     = 1'b1;
          rep_status = ST_NOT_WAV;
        end else begin
          fetch_go   = 1'b1;
          fetch_base = OFF_W'(8);
          fetch_len  = 4'd4;
          fetch_ret  = S_WAVE;
        end
      end
      S_WAVE: begin
        if (acc[31:0] != TAG_WAVE) begin
          rep_go     = 1'b1;
          rep_status = ST_NOT_WAV;
        end
      end
      S_WALK: begin
        if (walk_fits) begin
          fetch_go   = 1'b1;
          fetch_base = off;
          fetch_len  = 4'd8;
          fetch_ret  = S_CHUNK;
        end
      end
      S_FMTCHK: begin
        if (has_fmt && has_dat) begin
          fetch_go   = 1'b1;
          fetch_base = OFF_W'(fmt_at);
          fetch_len  = 4'd8;
          fetch_ret  = S_FMT1;
        end else begin
          rep_go     = 1'b1;
          rep_status = ST_MISSING;
        end
      end
      S_FMT1: begin
        // bits per sample sits 14 bytes into the fmt body
        fetch_go   = 1'b1;
        fetch_base = OFF_W'(fmt_at) + OFF_W'(14);
        fetch_len  = 4'd2;
        fetch_ret  = S_FMT2;
      end
      S_FMT2: begin
        if (chan_bad) begin
          rep_go     = 1'b1;
          rep_status = ST_CHANNELS;
          rep_rate   = 1'b1;
        end else if (!kind_ok) begin
          rep_go     = 1'b1;
          rep_status = ST_FORMAT;
          rep_rate   = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      S_FRAMES: begin
        rep_go   = 1'b1;
        rep_rate = 1'b1;
        if (quotient == 32'd0) begin
          rep_status = ST_EMPTY;
        end else if (rate_bad) begin
          rep_status = ST_RATE;
        end else begin
          rep_status = ST_OK;
        end
      end
      S_FRAME: frm_go = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_hash     <= '0;
      hash_check_enable <= 1'b0;
      engine_rate       <= '0;
      lead_point        <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXPECTED_HASH: expected_hash     <= cfg_data;
        REG_HASH_ENABLE:   hash_check_enable <= cfg_data[0];
        REG_ENGINE_RATE:   engine_rate       <= cfg_data[18:0];
        REG_LEAD_POINT:    lead_point        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // byte requests and load results
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_hash <= FNV_BASIS;
      overflowed   <= 1'b0;
      file_closed  <= 1'b1;
      loaded_ok    <= 1'b0;
      data_start   <= '0;
      frames_total <= '0;
      sample_kind  <= KIND_PCM16;
      stereo_flag  <= 1'b0;
      read_index   <= '0;
    end else begin
      if (state == S_IDLE && in_acc && !opcode) begin
        running_hash <= fnv_step(hash_base, file_byte);
        file_closed  <= end_of_file;
        if (file_closed) begin
          loaded_ok <= 1'b0;
        end
        if (cnt_base < CW'(MAX_BYTES)) begin
          byte_count <= cnt_base + 1'b1;
          overflowed <= ovf_base;
        end else begin
          byte_count <= cnt_base;
          overflowed <= 1'b1;
        end
      end
      if (state == S_FMT2 && !chan_bad && kind_ok) begin
        sample_kind <= kind_w;
        stereo_flag <= chan_r == 16'd2;
      end
      if (state == S_FRAMES && quotient != 32'd0 && !rate_bad) begin
        data_start   <= dat_at;
        frames_total <= frames_sat;
        read_index   <= '0;
        loaded_ok    <= 1'b1;
      end
      if (frm_go) begin
        read_index <= read_index + 1'b1;
      end
    end
  end

  // chunk walk registers
  always_ff @(posedge clk) begin
    if (state == S_WAVE) begin
      off     <= OFF_W'(12);
      has_fmt <= 1'b0;
      has_dat <= 1'b0;
    end
    if (state == S_CHUNK && !chunk_over) begin
      if (acc[31:0] == TAG_FMT) begin
        fmt_at  <= off_p8[CW-1:0];
        has_fmt <= 1'b1;
      end else if (acc[31:0] == TAG_DATA) begin
        dat_at  <= off_p8[CW-1:0];
        dat_len <= acc[63:32];
        has_dat <= 1'b1;
      end
      // odd chunks carry a pad byte
      off <= chunk_end + OFF_W'(acc[32]);
    end
    if (state == S_FMT1) begin
      fmt_code <= acc[15:0];
      chan_r   <= acc[31:16];
      fmt_rate <= acc[63:32];
    end
  end

  // byte fetch engine, one memory read a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      f_pend    <= 1'b0;
      f_issue   <= '0;
      f_len     <= '0;
      ret_state <= S_IDLE;
    end else if (fetch_go) begin
      f_base    <= fetch_base;
      f_len     <= fetch_len;
      f_issue   <= '0;
      f_pend    <= 1'b0;
      ret_state <= fetch_ret;
      acc       <= '0;
    end else if (state == S_FETCH) begin
      if (f_issue != f_len) begin
        f_issue <= f_issue + 1'b1;
        f_pend  <= 1'b1;
        f_pidx  <= f_issue[2:0];
        f_inr   <= rd_inr;
      end else begin
        f_pend <= 1'b0;
      end
      if (f_pend) begin
        // bytes past the end of the file read as zero
        acc[{f_pidx, 3'b000} +: 8] <= f_inr ? ram_rdata : 8'd0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rep_go || frm_go) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
    if (rep_go) begin
      kind          <= 1'b0;
      status        <= rep_status;
      left_sample   <= '0;
      right_sample  <= '0;
      channel_count <= (rep_status == ST_OK) ? chan_r[1:0] : 2'd0;
      file_rate     <= rep_rate ? fmt_rate : 32'd0;
      frame_count   <= (rep_status == ST_OK) ? frames_sat : 16'd0;
      last_frame    <= 1'b0;
    end else if (frm_go) begin
      kind          <= 1'b1;
      status        <= ST_OK;
      channel_count <= stereo_flag ? 2'd2 : 2'd1;
      file_rate     <= '0;
      frame_count   <= '0;
      last_frame    <= (read_index + 16'd1) == frames_total;
      if (stereo_flag && lead_point) begin
        left_sample  <= lr_sum[24:1];
        right_sample <= '0;
      end else begin
        left_sample  <= l_smp;
        right_sample <= r_smp;
      end
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == S_IDLE)
    else $error("request taken while sequencer busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rep_go || frm_go) |-> !(out_valid && out_stall))
    else $error("result written over a pending result");

  a_loaded_frames: assert property (@(posedge clk) disable iff (rst)
    loaded_ok |-> frames_total != 16'd0)
    else $error("load marked good with no frames");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(MAX_BYTES))
    else $error("byte count beyond memory depth");

  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> f_issue <= f_len)
    else $error("fetch issued past its length");

endmodule
`default_nettype wire
